>>> sv/sis_pkg.sv
`default_nettype none

package sis_pkg;

	// store size and derived widths
	localparam int CAPACITY = 256;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int RSP_CNT_W = 9;
	localparam int VAL_W    = 64;
	localparam int GRP      = 16;
	localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

	// request actions
	localparam logic [1:0] ACT_CONTAINS = 2'd0;
	localparam logic [1:0] ACT_ADD      = 2'd1;
	localparam logic [1:0] ACT_REMOVE   = 2'd2;
	localparam logic [1:0] ACT_CLEAR    = 2'd3;

	// width codes
	localparam logic [1:0] WC_INT16 = 2'd0;
	localparam logic [1:0] WC_INT32 = 2'd1;
	localparam logic [1:0] WC_INT64 = 2'd2;

	typedef struct packed {
		logic [1:0]              action;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic                 full_res;
		logic [RSP_CNT_W-1:0] count;
		logic [1:0]           width_code;
	} rsp_t;

	// command broadcast to every cell
	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CMP,
		PH_COMMIT
	} phase_t;

endpackage

`default_nettype wire

>>> sv/sis_cell.sv
`default_nettype none

module sis_cell import sis_pkg::*; (
	input  wire logic                    clk,
	input  wire cell_cmd_t               cmd,
	input  wire logic signed [VAL_W-1:0] value,
	input  wire logic                    occ,
	input  wire logic                    left_lt,
	input  wire logic signed [VAL_W-1:0] left_member,
	input  wire logic signed [VAL_W-1:0] right_member,
	output logic signed [VAL_W-1:0]      member,
	output logic                         lt,
	output logic                         eq
);

	logic signed [VAL_W-1:0] member_q;
	logic                    lt_s2;

	// local match against the broadcast operand
	assign eq = occ && (member_q == value);

	// remember whether this slot sorts below the operand
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			lt_s2 <= occ && (member_q < value);
		end
	end

	// insert shifts right from the left neighbor, delete pulls from the right
	always_ff @(posedge clk) begin
		if (cmd.ins && !lt_s2) begin
			member_q <= left_lt ? value : left_member;
		end else if (cmd.del && !lt_s2) begin
			member_q <= right_member;
		end
	end

	assign member = member_q;
	assign lt     = lt_s2;

endmodule

`default_nettype wire

>>> sv/sorted_integer_set.sv
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | req_t: action, value
// rsp     | out       | rsp_valid/rsp_stall | rsp_t: hit, full_res, count, width_code
//
// each request passes through a compare phase, in which every cell checks its
// member against the operand, and then a commit phase that reduces the match bits and
// shifts the cells; the next request is taken at the commit edge.
// reset clears the member count, the width and the response valid at once;
// member cells are not cleared and no sweep is needed.
// a stalled response holds the commit, which holds the request side.

`default_nettype none

module sorted_integer_set import sis_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	phase_t phase_q, phase_d;

	logic [1:0]              action_s1;
	logic signed [VAL_W-1:0] value_s1;
	logic [CNT_W-1:0]        count_q, count_d;
	logic [1:0]              width_q, width_d;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q, rsp_d;

	logic req_xfer;
	logic can_commit;
	logic commit;
	logic cmd_cmp;
	logic cmd_ins;
	logic cmd_del;
	cell_cmd_t cmd;

	logic signed [VAL_W-1:0] member [CAPACITY];
	logic [CAPACITY-1:0]     lt;
	logic [CAPACITY-1:0]     eq;
	logic [NGRP-1:0]         grp_s2;

	logic present;
	logic full;
	logic [1:0] need_w;

	assign req_xfer   = req_valid && !req_stall;
	assign can_commit = !rsp_valid_q || !rsp_stall;

	// phase sequencer, next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE:   if (req_valid) phase_d = PH_CMP;
			PH_CMP:    phase_d = PH_COMMIT;
			PH_COMMIT: begin
				if (can_commit) phase_d = req_valid ? PH_CMP : PH_IDLE;
			end
			default:   phase_d = PH_IDLE;
		endcase
	end

	// phase sequencer, outputs
	always_comb begin
		req_stall = 1'b1;
		commit    = 1'b0;
		cmd_cmp   = 1'b0;
		unique case (phase_q)
			PH_IDLE:   req_stall = 1'b0;
			PH_CMP:    cmd_cmp = 1'b1;
			PH_COMMIT: begin
				commit    = can_commit;
				req_stall = !can_commit;
			end
			default:   req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// command broadcast to the row
	assign cmd = '{cmp: cmd_cmp, ins: cmd_ins, del: cmd_del};

	// operand capture
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			action_s1 <= req.action;
			value_s1  <= req.value;
		end
	end

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic                    occ;
		logic                    left_lt;
		logic signed [VAL_W-1:0] left_member;
		logic signed [VAL_W-1:0] right_member;

		assign occ = count_q > IDX;
		if (i == 0) begin : g_head
			assign left_lt     = 1'b1;
			assign left_member = value_s1;
		end else begin : g_body
			assign left_lt     = lt[i-1];
			assign left_member = member[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_member = member[i];
		end else begin : g_mid
			assign right_member = member[i+1];
		end

		sis_cell u_cell (
			.clk          (clk),
			.cmd          (cmd),
			.value        (value_s1),
			.occ          (occ),
			.left_lt      (left_lt),
			.left_member  (left_member),
			.right_member (right_member),
			.member       (member[i]),
			.lt           (lt[i]),
			.eq           (eq[i])
		);
	end

	// first level of the match reduction, registered per group
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		localparam int LO = g * GRP;
		localparam int HI = (LO + GRP > CAPACITY) ? CAPACITY - 1 : LO + GRP - 1;
		always_ff @(posedge clk) begin
			if (cmd.cmp) grp_s2[g] <= |eq[HI:LO];
		end
	end

	assign present = |grp_s2;
	assign full    = count_q >= CNT_W'(CAPACITY);

	// narrowest signed width of the operand
	always_comb begin
		if (&value_s1[VAL_W-1:15] || ~|value_s1[VAL_W-1:15]) begin
			need_w = WC_INT16;
		end else if (&value_s1[VAL_W-1:31] || ~|value_s1[VAL_W-1:31]) begin
			need_w = WC_INT32;
		end else begin
			need_w = WC_INT64;
		end
	end

	// action decode: new count, width and response
	always_comb begin
		count_d = count_q;
		width_d = width_q;
		cmd_ins = 1'b0;
		cmd_del = 1'b0;
		rsp_d   = '0;
		unique case (action_s1)
			ACT_CONTAINS: rsp_d.hit = present;
			ACT_ADD: begin
				if (!present && full) begin
					rsp_d.full_res = 1'b1;
				end else if (!present) begin
					cmd_ins   = commit;
					rsp_d.hit = 1'b1;
					count_d   = count_q + CNT_W'(1);
					if (need_w > width_q) width_d = need_w;
				end
			end
			ACT_REMOVE: begin
				if (present) begin
					cmd_del   = commit;
					rsp_d.hit = 1'b1;
					count_d   = count_q - CNT_W'(1);
				end
			end
			ACT_CLEAR: begin
				rsp_d.hit = 1'b1;
				count_d   = '0;
				width_d   = WC_INT16;
			end
			default: rsp_d = '0;
		endcase
		rsp_d.count      = RSP_CNT_W'(count_d);
		rsp_d.width_code = width_d;
	end

	// set state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			width_q <= WC_INT16;
		end else if (commit) begin
			count_q <= count_d;
			width_q <= width_d;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("member count above capacity");

	a_cmp_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CMP |=> phase_q == PH_COMMIT)
		else $error("compare not followed by commit");

	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.full_res |-> !rsp.hit)
		else $error("refused add reported as hit");

	a_width_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.width_code <= WC_INT64)
		else $error("illegal width code");
`endif

endmodule

`default_nettype wire
